[rtl/core/assert_macros.svh]
// assert_macros.svh
// Concurrent assertion macros for the RTL checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define TFS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge
`define TFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/core/tfs_pkg.sv]
// ----------------------------------------------------------------------------
// tfs_pkg
// Types and constants of the telemetry frame stuffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfs_pkg;

   typedef logic [7:0] byte_type;

   // Bytes per packet, identifier included (2..8)
   localparam int PACKET_BYTES = 8;

   // Position of the last byte of a packet
   localparam logic [2:0] LAST_POS = 3'(PACKET_BYTES - 1);

   // Framing codes
   localparam byte_type FLAG_BYTE = 8'h7E;
   localparam byte_type ESC_BYTE  = 8'h7D;
   localparam byte_type ESC_XOR   = 8'h20;

   // Result kinds
   localparam logic KIND_WIRE    = 1'b0;
   localparam logic KIND_TRIGGER = 1'b1;

   // Results one byte can cause at most
   localparam int PEND_DEPTH = 4;

   typedef struct packed {
      byte_type data;
      logic     kind;
   } entry_type;

endpackage

`default_nettype wire

[rtl/core/telemetry_frame_stuffer.sv]
// ----------------------------------------------------------------------------
// telemetry_frame_stuffer
// Byte-stuffed packet framer with an end-around-carry checksum trailer.
// ----------------------------------------------------------------------------
// Each packet of PACKET_BYTES bytes arrives one byte per transfer. The first
// byte (device identifier) is held and yields no output. Every later byte
// goes out escaped (0x7E/0x7D become 0x7D, byte ^ 0x20) and is summed into an
// 8-bit ones-complement checksum. After the last byte the block sends the
// inverted checksum unescaped, then the identifier with tuser set. tlast marks
// the final output caused by each input byte. An input byte passes through an
// input register and a four-entry result list into the output register. The
// output register sends one result per cycle while rsp_tready is high. A held
// byte is processed only when the list is empty or its last entry leaves, so
// a byte that yields several results holds back the next input until then.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_stuffer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire tfs_pkg::byte_type req_tdata,   // [7:0] data_byte
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output tfs_pkg::byte_type      rsp_tdata,   // [7:0] out_byte
   output logic                   rsp_tuser,   // [0] out_kind
   output logic                   rsp_tlast    // run_last
);

   import tfs_pkg::*;

   // Input register
   logic      in_valid_ff, in_valid_in;
   byte_type  in_byte_ff, in_byte_in;

   // Packet state
   logic [2:0] pos_ff, pos_in;
   byte_type   sum_ff, sum_in;
   byte_type   id_ff, id_in;

   // Pending result list
   entry_type  pend_ff [PEND_DEPTH];
   entry_type  pend_in [PEND_DEPTH];
   logic [2:0] pend_cnt_ff, pend_cnt_in;

   // Output register
   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  rsp_data_ff, rsp_data_in;
   logic      rsp_user_ff, rsp_user_in;
   logic      rsp_last_ff, rsp_last_in;

   // Handshake control
   logic out_free;
   logic pop;
   logic take;

   // Byte processing
   logic       is_stuff;
   logic       is_last;
   logic [8:0] sum_wide;
   byte_type   sum_next;
   byte_type   csum;
   logic [2:0] load_cnt;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pop      = out_free && (pend_cnt_ff != 3'd0);
   assign take     = in_valid_ff &&
                     ((pend_cnt_ff == 3'd0) || ((pend_cnt_ff == 3'd1) && pop));
   assign req_tready = !in_valid_ff || take;

   // Escape test, end-around-carry sum and trailer
   assign is_stuff = (in_byte_ff == FLAG_BYTE) || (in_byte_ff == ESC_BYTE);
   assign is_last  = (pos_ff >= LAST_POS);
   assign sum_wide = {1'b0, sum_ff} + {1'b0, in_byte_ff};
   assign sum_next = sum_wide[7:0] + {7'd0, sum_wide[8]};
   assign csum     = ~sum_next;
   assign load_cnt = (is_stuff ? 3'd2 : 3'd1) + (is_last ? 3'd2 : 3'd0);

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      id_in        = id_ff;
      pend_in      = pend_ff;
      pend_cnt_in  = pend_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      // Load the output register from the head of the list
      if (out_free) begin
         rsp_valid_in = (pend_cnt_ff != 3'd0);
         rsp_data_in  = pend_ff[0].data;
         rsp_user_in  = pend_ff[0].kind;
         rsp_last_in  = (pend_cnt_ff == 3'd1);
      end

      // Advance the list
      if (pop) begin
         for (int i = 0; i < PEND_DEPTH - 1; i++) begin
            pend_in[i] = pend_ff[i + 1];
         end
         pend_cnt_in = pend_cnt_ff - 3'd1;
      end

      // Process the held byte
      if (take) begin
         if (pos_ff == 3'd0) begin
            id_in       = in_byte_ff;
            sum_in      = 8'h00;
            pos_in      = 3'd1;
            pend_cnt_in = 3'd0;
         end else begin
            pend_in[0].data = is_stuff ? ESC_BYTE : in_byte_ff;
            pend_in[0].kind = KIND_WIRE;
            pend_in[1].data = is_stuff ? (in_byte_ff ^ ESC_XOR) : csum;
            pend_in[1].kind = KIND_WIRE;
            pend_in[2].data = is_stuff ? csum : id_ff;
            pend_in[2].kind = is_stuff ? KIND_WIRE : KIND_TRIGGER;
            pend_in[3].data = id_ff;
            pend_in[3].kind = KIND_TRIGGER;
            pend_cnt_in     = load_cnt;
            if (is_last) begin
               pos_in = 3'd0;
               sum_in = 8'h00;
               id_in  = 8'h00;
            end else begin
               pos_in = pos_ff + 3'd1;
               sum_in = sum_next;
            end
         end
      end

      // Capture the next input transfer
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= 3'd0;
         sum_ff       <= 8'h00;
         id_ff        <= 8'h00;
         pend_cnt_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         id_ff        <= id_in;
         pend_cnt_ff  <= pend_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/core/tfs_checker.sv]
// ----------------------------------------------------------------------------
// tfs_checker
// Port-level checks of the telemetry frame stuffer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tfs_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire tfs_pkg::byte_type rsp_tdata,
   input wire logic              rsp_tuser,
   input wire logic              rsp_tlast
);

   import tfs_pkg::*;

   logic       rsp_stall;
   logic       rsp_trigger;
   logic [9:0] rsp_word;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_trigger = rsp_tvalid && (rsp_tuser == KIND_TRIGGER);
   assign rsp_word    = {rsp_tdata, rsp_tuser, rsp_tlast};

   // Hold a stalled output transfer
   `TFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // Identifier trigger always closes the run of its input byte
   `TFS_ASSERT_IMPLY(a_trigger_last, clock, reset, rsp_trigger, rsp_tlast)

   // Output is empty and input is ready right after reset
   `TFS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready)

   // No output can leave in the cycle right after reset releases
   `TFS_ASSERT_IMPLY(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_tvalid)

endmodule

bind telemetry_frame_stuffer tfs_checker u_tfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
